// ===== rtl/sbaf_pkg.sv =====
// ----------------------------------------------------------------------------
// sbaf_pkg: shared constants, widths and helpers of the slot bitmap allocator
// Field widths, transfer kinds, default geometry and mask helpers.
// ----------------------------------------------------------------------------
package sbaf_pkg;

    localparam int SLOTS_PER_PAGE_DEF = 64;
    localparam int BYTES_PER_SLOT_DEF = 64;

    localparam int MASK_W  = 64;
    localparam int LEN_W   = 12;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;
    localparam int POW_N   = 7;  // run-length powers 1, 2, 4 .. 64

    localparam int S_TDATA_W = 96;  // 89 bits of fields, padded to bytes
    localparam int M_TDATA_W = 96;  // 93 bits of fields, padded to bytes

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Mask of n consecutive slots starting at base, n in 0..64.
    function automatic logic [MASK_W-1:0] run_mask(
        input logic [SLOT_W-1:0]  base,
        input logic [COUNT_W-1:0] n
    );
        logic [MASK_W:0] ones;
        ones = (65'd1 << n) - 65'd1;
        return ones[MASK_W-1:0] << base;
    endfunction

    // Floor of log2 for a constant run length of 1..64.
    function automatic int floor_log2(input int n);
        int lg;
        lg = 0;
        for (int i = 0; i < POW_N; i++) begin
            if (n >= (1 << i)) begin
                lg = i;
            end
        end
        return lg;
    endfunction

endpackage

// ===== rtl/slot_bitmap_alloc_free.sv =====
// ----------------------------------------------------------------------------
// slot_bitmap_alloc_free: first-fit slot allocate / free over one page mask
// Computes the new free mask, longest free run and page-empty flag for each
// transfer, and the allocated base, slot need and last-slot fill for allocations.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel (s_tvalid / s_tready / s_tdata / s_tuser) carries one
//   request per transfer: s_tuser selects allocate or free, s_tdata holds the
//   page free mask and the operands. The master channel (m_tvalid / m_tready
//   / m_tdata) returns exactly one result per request, in order.
//   A request accepted at a clock edge is shown at m_tdata right after
//   that edge. Throughput is one transfer per cycle while m_tready is high;
//   all the work sits in one combinational pass in front of the result
//   register, so the figure is set by that single register stage.
//   When the receiver stalls, the result register holds its transfer and
//   s_tready drops until the result is taken; while m_tready is high a new
//   request is taken in the same cycle the old result leaves.
//   Reset (aresetn low at a clock edge) empties the result register; the
//   block keeps no other state, so nothing else needs clearing.
//   Errors (no run fits, zero length, bad free range) raise the error bit
//   and pass the input mask on unchanged.
// ----------------------------------------------------------------------------
module slot_bitmap_alloc_free #(
    parameter int SLOTS_PER_PAGE = sbaf_pkg::SLOTS_PER_PAGE_DEF,
    parameter int BYTES_PER_SLOT = sbaf_pkg::BYTES_PER_SLOT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [63:0] cur_mask, [75:64] byte_length, [81:76] run_first,
    // [88:82] slot_count, [95:89] zero
    input  logic [sbaf_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] kind (0 allocate, 1 free)
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [63:0] next_mask, [69:64] slot_base, [76:70] slots_used,
    // [83:77] tail_bytes, [90:84] longest_free_run, [91] page_empty,
    // [92] error, [95:93] zero
    output logic [sbaf_pkg::M_TDATA_W-1:0] m_tdata
);
    import sbaf_pkg::*;

    // Page mask: bits at or above the page size are absent slots.
    localparam logic [MASK_W:0]   PAGE_WIDE = (65'd1 << SLOTS_PER_PAGE) - 65'd1;
    localparam logic [MASK_W-1:0] PAGE_MASK = PAGE_WIDE[MASK_W-1:0];

    // Reciprocal for the slot division; exact for every 12-bit length.
    localparam int RECIP_SH = 24;
    localparam int RECIP    = (1 << RECIP_SH) / BYTES_PER_SLOT + 1;
    localparam int PROD_W   = 33;
    localparam int Q_W      = 9;

    // ---------------- request fields ----------------
    logic                     kind;
    logic [MASK_W-1:0]        mask;
    logic [LEN_W-1:0]         byte_length;
    logic [SLOT_W-1:0]        run_first;
    logic [COUNT_W-1:0]       slot_count;

    assign kind        = s_tuser;
    assign mask        = s_tdata[63:0] & PAGE_MASK;
    assign byte_length = s_tdata[75:64];
    assign run_first   = s_tdata[81:76];
    assign slot_count  = s_tdata[88:82];

    // ---------------- slot need and last-slot fill ----------------
    logic [LEN_W-1:0]   len_m1;
    logic [PROD_W-1:0]  recip_prod;
    logic [Q_W-1:0]     quot;
    logic [23:0]        quot_bytes;
    logic [LEN_W-1:0]   rem;
    logic [Q_W:0]       need;
    logic [LEN_W:0]     last_full;
    logic [COUNT_W-1:0] need_sat;
    logic [COUNT_W-1:0] last_sat;

    always_comb begin
        len_m1     = byte_length - LEN_W'(1);
        recip_prod = PROD_W'(len_m1) * PROD_W'(RECIP);
        quot       = recip_prod[RECIP_SH +: Q_W];
        quot_bytes = 24'(quot) * 24'(BYTES_PER_SLOT);
        rem        = LEN_W'(24'(len_m1) - quot_bytes);
        need       = {1'b0, quot} + (Q_W+1)'(1);
        last_full  = {1'b0, rem} + (LEN_W+1)'(1);
        need_sat   = (need > (Q_W+1)'(127)) ? COUNT_W'(127) : need[COUNT_W-1:0];
        last_sat   = (last_full > (LEN_W+1)'(127)) ? COUNT_W'(127)
                                                    : last_full[COUNT_W-1:0];
    end

    // ---------------- first-fit search ----------------
    // fit_pow[k] bit b: slots b .. b+2^k-1 are all free.
    logic [MASK_W-1:0]  fit_pow [0:POW_N-1];
    logic [COUNT_W-1:0] run_n;
    logic [2:0]         run_lg;
    logic [COUNT_W-1:0] run_off;
    logic [MASK_W-1:0]  fit_starts;
    logic               fit_found;
    logic [SLOT_W-1:0]  fit_base;

    always_comb begin
        fit_pow[0] = mask;
        for (int k = 1; k < POW_N; k++) begin
            fit_pow[k] = fit_pow[k-1] & (fit_pow[k-1] >> (1 << (k-1)));
        end
        run_n  = need[COUNT_W-1:0];
        run_lg = '0;
        for (int i = 0; i < POW_N; i++) begin
            if (run_n[i]) begin
                run_lg = 3'(i);
            end
        end
        // A run of n fits at b when the two 2^lg windows covering it fit.
        run_off    = run_n - (COUNT_W'(1) << run_lg);
        fit_starts = fit_pow[run_lg] & (fit_pow[run_lg] >> run_off);
        fit_found  = |fit_starts;
        fit_base   = '0;
        for (int b = MASK_W - 1; b >= 0; b--) begin
            if (fit_starts[b]) begin
                fit_base = SLOT_W'(b);
            end
        end
    end

    // ---------------- operation result ----------------
    logic [MASK_W-1:0]  res_mask;
    logic [SLOT_W-1:0]  res_base;
    logic [COUNT_W-1:0] res_used;
    logic [COUNT_W-1:0] res_last;
    logic               res_err;

    always_comb begin
        res_mask = mask;
        res_base = '0;
        res_used = '0;
        res_last = '0;
        res_err  = 1'b0;
        case (kind)
            KIND_ALLOC: begin
                if (byte_length == '0) begin
                    res_err = 1'b1;
                end else begin
                    res_used = need_sat;
                    res_last = last_sat;
                    if (need > (Q_W+1)'(SLOTS_PER_PAGE) || !fit_found) begin
                        res_err = 1'b1;
                    end else begin
                        res_base = fit_base;
                        res_mask = mask & ~run_mask(fit_base, run_n);
                    end
                end
            end
            KIND_FREE: begin
                if (slot_count == '0 ||
                    ({2'b00, run_first} + {1'b0, slot_count}) >
                    (COUNT_W+1)'(SLOTS_PER_PAGE)) begin
                    res_err = 1'b1;
                end else begin
                    res_mask = mask | run_mask(run_first, slot_count);
                end
            end
            default: begin
                res_err = 1'b1;
            end
        endcase
    end

    // ---------------- longest free run of the new mask ----------------
    logic [MASK_W-1:0]  res_pow [0:POW_N-1];
    logic [COUNT_W-1:0] res_longest;

    always_comb begin
        int lg;
        res_pow[0] = res_mask;
        for (int k = 1; k < POW_N; k++) begin
            res_pow[k] = res_pow[k-1] & (res_pow[k-1] >> (1 << (k-1)));
        end
        // Runs of each length checked in parallel; keep the longest hit.
        res_longest = '0;
        for (int n = 1; n <= SLOTS_PER_PAGE; n++) begin
            lg = floor_log2(n);
            if (|(res_pow[lg] & (res_pow[lg] >> (n - (1 << lg))))) begin
                res_longest = COUNT_W'(n);
            end
        end
    end

    // ---------------- result register ----------------
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 s_fire;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            // advance: take the new request, or drop the delivered result
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= {3'b000, res_err, (res_mask == PAGE_MASK), res_longest,
                           res_last, res_used, res_base, res_mask};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
